// ===== hw/rtl/cic_pkg.sv =====
// Shared types and constants of the cell index compactor.
// Item structs, function codes, register indexes, controller command/status.
// No dependencies.
package cic_pkg;

    localparam int DEVICES_DEF          = 4;
    localparam int CELLS_PER_DEVICE_DEF = 12;
    localparam int SLOTS_PER_GROUP_DEF  = 3;

    localparam int MASK_W  = 48;
    localparam int IDX_W   = 6;
    localparam int CELL_W  = 4;
    localparam int DMASK_W = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [1:0] FUNC_CELL = 2'd0;
    localparam logic [1:0] FUNC_AUX  = 2'd1;
    localparam logic [1:0] FUNC_DIS  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_CELL_MASK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AUX_MASK  = 1'd1;

    typedef struct packed {
        logic [1:0]  func;
        logic [1:0]  device;
        logic [1:0]  register_group;
        logic [1:0]  slot;
        logic [3:0]  mux_channel;
        logic [15:0] voltage;
        logic [5:0]  position;
        logic        discharge_on;
    } t_in_item;

    typedef struct packed {
        logic               store_valid;
        logic [IDX_W-1:0]   result_index;
        logic [15:0]        voltage_out;
        logic [1:0]         discharge_device;
        logic [DMASK_W-1:0] discharge_mask;
        logic               status;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic last_step;
    } t_stat;

endpackage

// ===== hw/rtl/cic_ctrl.sv =====
// Controller of the cell index compactor: load, device walk, finish.
// Drives datapath commands and the output valid flag. Depends on cic_pkg.
module cic_ctrl import cic_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_WALK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        o_in_ready   = (r_state == S_IDLE);
        o_cmd.load   = o_in_ready && i_in_valid;
        o_cmd.step   = (r_state == S_WALK);
        o_cmd.finish = (r_state == S_DONE) && (!r_out_valid || i_out_ready);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd.load) n_state = S_WALK;
            end
            S_WALK: begin
                if (i_stat.last_step) n_state = S_DONE;
            end
            S_DONE: begin
                if (o_cmd.finish) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hw/rtl/cic_datapath.sv =====
// Datapath of the cell index compactor: enable masks, per-device rank and
// select walk, discharge mask store and output register. Depends on cic_pkg.
module cic_datapath import cic_pkg::*; #(
    parameter int DEVICES          = DEVICES_DEF,
    parameter int CELLS_PER_DEVICE = CELLS_PER_DEVICE_DEF,
    parameter int SLOTS_PER_GROUP  = SLOTS_PER_GROUP_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_cmd                 i_cmd,
    output t_stat                o_stat,
    input  t_in_item             i_in_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MASK_W-1:0]    i_cfg_data,
    output t_out_item            o_out_item
);

    localparam int DEV_W = (DEVICES > 1) ? $clog2(DEVICES) : 1;
    localparam int EXT_W = DEVICES * CELLS_PER_DEVICE;
    localparam int TOTAL = (EXT_W > MASK_W) ? MASK_W : EXT_W;
    localparam int CNT_W = $clog2(CELLS_PER_DEVICE + 1);
    localparam int N_W   = IDX_W + 1;

    logic [MASK_W-1:0]  r_cell_mask;
    logic [MASK_W-1:0]  r_aux_mask;
    t_in_item           r_item;
    logic [DEV_W-1:0]   r_step;
    logic [IDX_W-1:0]   r_acc;
    logic               r_found;
    logic [DEV_W-1:0]   r_hit_dev;
    logic [CELL_W-1:0]  r_hit_cell;
    logic [DMASK_W-1:0] r_dis [DEVICES];
    t_out_item          r_out;

    logic [CELL_W-1:0]           dcell;
    logic [N_W-1:0]              n_input;
    logic                        present;
    logic                        enabled;
    logic [MASK_W-1:0]           sel_mask;
    logic [EXT_W-1:0]            ext;
    logic [CELLS_PER_DEVICE-1:0] chunk;
    logic [CELLS_PER_DEVICE-1:0] below;
    logic [CNT_W-1:0]            cnt;
    logic [N_W-1:0]              run_sum;
    logic [IDX_W-1:0]            k_sel;
    logic [CELL_W-1:0]           sel_cell;
    logic                        hit;
    logic [CNT_W-1:0]            pre;
    logic [DMASK_W-1:0]          cur_dis;
    logic [DMASK_W-1:0]          new_dis;
    logic [DMASK_W-1:0]          dis_bit;
    t_out_item                   res;

    always_comb begin
        if (r_item.func == FUNC_CELL) begin
            dcell = CELL_W'(int'(r_item.register_group) * SLOTS_PER_GROUP
                            + int'(r_item.slot));
        end else begin
            dcell = r_item.mux_channel;
        end
        n_input  = N_W'(int'(r_item.device) * CELLS_PER_DEVICE + int'(dcell));
        present  = (int'(r_item.device) < DEVICES) && (int'(dcell) < CELLS_PER_DEVICE)
                   && (int'(n_input) < TOTAL);
        sel_mask = (r_item.func == FUNC_AUX) ? r_aux_mask : r_cell_mask;
        enabled  = present && sel_mask[n_input[IDX_W-1:0]];
        ext      = EXT_W'(sel_mask);
        chunk    = ext[int'(r_step) * CELLS_PER_DEVICE +: CELLS_PER_DEVICE];
    end

    always_comb begin
        for (int j = 0; j < CELLS_PER_DEVICE; j++) begin
            if (r_item.func == FUNC_DIS) begin
                below[j] = 1'b1;
            end else begin
                below[j] = (int'(r_step) < int'(r_item.device))
                           || ((int'(r_step) == int'(r_item.device)) && (j < int'(dcell)));
            end
        end
        cnt = '0;
        for (int j = 0; j < CELLS_PER_DEVICE; j++) begin
            cnt = cnt + CNT_W'(chunk[j] & below[j]);
        end
        run_sum = N_W'(r_acc) + N_W'(cnt);
        k_sel   = r_item.position - r_acc;
        hit     = (r_item.func == FUNC_DIS) && !r_found
                  && (run_sum > N_W'(r_item.position));
        sel_cell = '0;
        for (int j = 0; j < CELLS_PER_DEVICE; j++) begin
            pre = '0;
            for (int i = 0; i < j; i++) begin
                pre = pre + CNT_W'(chunk[i]);
            end
            if (chunk[j] && (IDX_W'(pre) == k_sel)) sel_cell = CELL_W'(j);
        end
    end

    assign o_stat.last_step = (int'(r_step) == DEVICES - 1);

    always_comb begin
        cur_dis = r_dis[r_hit_dev];
        dis_bit = DMASK_W'(1) << r_hit_cell;
        new_dis = r_item.discharge_on ? (cur_dis | dis_bit) : (cur_dis & ~dis_bit);
        res     = '0;
        case (r_item.func)
            FUNC_CELL, FUNC_AUX: begin
                res.store_valid  = enabled;
                res.result_index = enabled ? r_acc : '0;
                res.voltage_out  = r_item.voltage;
            end
            FUNC_DIS: begin
                if (r_found) begin
                    res.discharge_device = 2'(r_hit_dev);
                    res.discharge_mask   = new_dis;
                end else begin
                    res.status = 1'b1;
                end
            end
            default: res.status = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_mask <= '0;
            r_aux_mask  <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_CELL_MASK: r_cell_mask <= i_cfg_data;
                CFG_AUX_MASK:  r_aux_mask  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int d = 0; d < DEVICES; d++) r_dis[d] <= '0;
        end else if (i_cmd.finish && (r_item.func == FUNC_DIS) && r_found) begin
            r_dis[r_hit_dev] <= new_dis;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_cmd.load) begin
            r_found <= 1'b0;
        end else if (i_cmd.step && hit) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_in_item;
            r_step <= '0;
            r_acc  <= '0;
        end else if (i_cmd.step) begin
            r_step <= r_step + DEV_W'(1);
            if (hit) begin
                r_hit_dev  <= r_step;
                r_hit_cell <= sel_cell;
            end else if (!r_found) begin
                r_acc <= run_sum[IDX_W-1:0];
            end
        end
        if (i_cmd.finish) r_out <= res;
    end

    assign o_out_item = r_out;

endmodule

// ===== hw/rtl/cell_index_compactor.sv =====
// Top level of the cell index compactor: controller plus datapath.
// Depends on cic_pkg, cic_ctrl and cic_datapath.
//
// Usage: readings and discharge requests enter on the input channel
// (i_in_valid / o_in_ready, payload i_in_item). Each gives one result on the
// output channel (o_out_valid / i_out_ready, payload o_out_item): store flag
// and compacted index for a reading, updated device discharge mask for a
// discharge request, status 1 for a rejected position or unused function.
// Enable masks are written through i_cfg_we / i_cfg_index / i_cfg_data by the
// user only while the block is idle; the block itself does not enforce this.
// Timing: one item at a time. After acceptance the datapath walks the chain
// one device per cycle, counting enabled inputs of that device, then forms
// the result and writes it to the output register once that register can
// take it. A new item is accepted only once the last result is registered,
// after the per-device walk of the rank/select counter.
// Reset clears both masks, all discharge masks and the output valid flag.
// A stalled receiver holds the result in the output register; the next item
// may still be accepted and walked, and waits for the register to empty.
module cell_index_compactor import cic_pkg::*; #(
    parameter int DEVICES          = DEVICES_DEF,
    parameter int CELLS_PER_DEVICE = CELLS_PER_DEVICE_DEF,
    parameter int SLOTS_PER_GROUP  = SLOTS_PER_GROUP_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_item,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_item,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [MASK_W-1:0]    i_cfg_data
);

    t_cmd  cmd;
    t_stat stat;

    cic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    cic_datapath #(
        .DEVICES          (DEVICES),
        .CELLS_PER_DEVICE (CELLS_PER_DEVICE),
        .SLOTS_PER_GROUP  (SLOTS_PER_GROUP)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_in_item   (i_in_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_out_item  (o_out_item)
    );

endmodule

// ===== hw/rtl/cic_checker.sv =====
// Port-level checks of the cell index compactor, bound to the top level.
// Depends on cic_pkg and cell_index_compactor.
module cic_checker import cic_pkg::*; (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input t_out_item            o_out_item
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("item accepted while another is in work");

    a_store_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.store_valid |->
            !o_out_item.status && (int'(o_out_item.result_index) < MASK_W))
        else $error("stored reading with bad status or index");

    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.status |->
            !o_out_item.store_valid && (o_out_item.discharge_mask == '0)
            && (o_out_item.discharge_device == '0))
        else $error("rejected item carries data");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

endmodule

bind cell_index_compactor cic_checker u_cic_checker (.*);
